>>> rtl/core/v3alu_pkg.sv
// ============================================================================
// v3alu_pkg: shared types and helpers of the 3D vector unit
// Item structs, command codes and the saturating truncation helpers.
// ============================================================================
`default_nettype none

package v3alu_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_W        = 32;
    localparam int PROD_W        = 64;
    localparam int ACC_W         = 66;
    localparam int SQRT_STAGES   = 32;

    typedef logic [3:0] t_cmd;

    localparam t_cmd CMD_ADD   = 4'd0;
    localparam t_cmd CMD_SUB   = 4'd1;
    localparam t_cmd CMD_DOT   = 4'd2;
    localparam t_cmd CMD_CROSS = 4'd3;
    localparam t_cmd CMD_SCALE = 4'd4;
    localparam t_cmd CMD_DIV   = 4'd5;
    localparam t_cmd CMD_MAG   = 4'd6;
    localparam t_cmd CMD_UNIT  = 4'd7;
    localparam t_cmd CMD_ORTH  = 4'd8;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef t_word [2:0] t_vec;

    typedef struct packed {
        t_cmd  cmd;
        t_word ax;
        t_word ay;
        t_word az;
        t_word bx;
        t_word by_comp;
        t_word bz;
        t_word scalar;
    } t_in_item;

    typedef struct packed {
        t_word res_x;
        t_word res_y;
        t_word res_z;
        t_word res_scalar;
        logic  overflow;
        logic  div_zero;
    } t_out_item;

    typedef struct packed {
        t_word val;
        logic  ov;
    } t_sat;

    localparam t_word WORD_MAX = 32'sh7FFFFFFF;
    localparam t_word WORD_MIN = 32'sh80000000;

    localparam logic signed [ACC_W-1:0] ACC_MAX = 66'sd2147483647;
    localparam logic signed [ACC_W-1:0] ACC_MIN = -66'sd2147483648;

    function automatic t_sat sat32(input logic signed [ACC_W-1:0] x);
        t_sat r;
        r.ov  = 1'b0;
        r.val = x[WORD_W-1:0];
        if (x > ACC_MAX) begin
            r.ov  = 1'b1;
            r.val = WORD_MAX;
        end else if (x < ACC_MIN) begin
            r.ov  = 1'b1;
            r.val = WORD_MIN;
        end
        return r;
    endfunction

    // Divides by 2^fb with truncation toward zero, then saturates.
    function automatic t_sat trunc_sat(input logic signed [ACC_W-1:0] x, input int fb);
        logic signed [ACC_W-1:0] bias;
        logic signed [ACC_W-1:0] t;
        bias = (ACC_W'(1) << fb) - ACC_W'(1);
        t    = x[ACC_W-1] ? ((x + bias) >>> fb) : (x >>> fb);
        return sat32(t);
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/v3alu_delay.sv
// ============================================================================
// v3alu_delay: enabled shift line
// Carries side data alongside the long arithmetic stages.
// ============================================================================
`default_nettype none

module v3alu_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_d
);

    logic [WIDTH-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_d = r_tap[DEPTH-1];

endmodule

`default_nettype wire

>>> rtl/core/v3alu_lane.sv
// ============================================================================
// v3alu_lane: per-component arithmetic lane
// Products, add/sub/cross/scale with saturation, and the component square.
// ============================================================================
`default_nettype none

module v3alu_lane #(
    parameter int FRAC_BITS = v3alu_pkg::FRAC_BITS_DEF,
    parameter int LANE      = 0
) (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  v3alu_pkg::t_cmd                        i_cmd,
    input  v3alu_pkg::t_vec                        i_a,
    input  v3alu_pkg::t_vec                        i_b,
    input  v3alu_pkg::t_word                       i_scalar,
    output logic signed [v3alu_pkg::PROD_W-1:0]    o_prod,
    output v3alu_pkg::t_word                       o_res,
    output logic                                   o_ov,
    output v3alu_pkg::t_word                       o_vec,
    output logic [v3alu_pkg::PROD_W-1:0]           o_sq
);

    localparam int J1 = (LANE + 1) % 3;
    localparam int J2 = (LANE + 2) % 3;

    v3alu_pkg::t_word n_op1a, n_op1b, n_op2a, n_op2b;
    logic signed [v3alu_pkg::PROD_W-1:0] r_p1, r_p2, n_p1, n_p2;
    v3alu_pkg::t_cmd  r_cmd1, r_cmd2;
    v3alu_pkg::t_word r_a1, r_b1, r_a2;
    v3alu_pkg::t_sat  r_res2, n_res2;
    v3alu_pkg::t_word r_vec3, n_v;
    logic signed [v3alu_pkg::PROD_W-1:0] n_sq;
    logic [v3alu_pkg::PROD_W-1:0] r_sq3;

    always_comb begin
        n_op1a = '0;
        n_op1b = '0;
        n_op2a = '0;
        n_op2b = '0;
        case (i_cmd) inside
            v3alu_pkg::CMD_DOT: begin
                n_op1a = $signed(i_a[LANE]);
                n_op1b = $signed(i_b[LANE]);
            end
            v3alu_pkg::CMD_CROSS, v3alu_pkg::CMD_ORTH: begin
                n_op1a = $signed(i_a[J1]);
                n_op1b = $signed(i_b[J2]);
                n_op2a = $signed(i_a[J2]);
                n_op2b = $signed(i_b[J1]);
            end
            v3alu_pkg::CMD_SCALE: begin
                n_op1a = $signed(i_a[LANE]);
                n_op1b = i_scalar;
            end
            default: begin
            end
        endcase
        n_p1 = n_op1a * n_op1b;
        n_p2 = n_op2a * n_op2b;
    end

    always_comb begin
        case (r_cmd1) inside
            v3alu_pkg::CMD_ADD:
                n_res2 = v3alu_pkg::sat32(v3alu_pkg::ACC_W'(r_a1) + v3alu_pkg::ACC_W'(r_b1));
            v3alu_pkg::CMD_SUB:
                n_res2 = v3alu_pkg::sat32(v3alu_pkg::ACC_W'(r_a1) - v3alu_pkg::ACC_W'(r_b1));
            v3alu_pkg::CMD_CROSS, v3alu_pkg::CMD_ORTH:
                n_res2 = v3alu_pkg::trunc_sat(
                    v3alu_pkg::ACC_W'(r_p1) - v3alu_pkg::ACC_W'(r_p2), FRAC_BITS);
            v3alu_pkg::CMD_SCALE:
                n_res2 = v3alu_pkg::trunc_sat(v3alu_pkg::ACC_W'(r_p1), FRAC_BITS);
            default:
                n_res2 = '0;
        endcase
    end

    always_comb begin
        n_v  = (r_cmd2 == v3alu_pkg::CMD_ORTH) ? r_res2.val : r_a2;
        n_sq = n_v * n_v;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1   <= n_p1;
            r_p2   <= n_p2;
            r_cmd1 <= i_cmd;
            r_a1   <= $signed(i_a[LANE]);
            r_b1   <= $signed(i_b[LANE]);
            r_res2 <= n_res2;
            r_cmd2 <= r_cmd1;
            r_a2   <= r_a1;
            r_vec3 <= n_v;
            r_sq3  <= n_sq;
        end
    end

    assign o_prod = r_p1;
    assign o_res  = r_res2.val;
    assign o_ov   = r_res2.ov;
    assign o_vec  = r_vec3;
    assign o_sq   = r_sq3;

endmodule

`default_nettype wire

>>> rtl/core/v3alu_sqrt.sv
// ============================================================================
// v3alu_sqrt: pipelined integer square root
// One result bit per stage, floor of the root of a 64-bit radicand.
// ============================================================================
`default_nettype none

module v3alu_sqrt (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic [v3alu_pkg::PROD_W-1:0]           i_rad,
    output logic [v3alu_pkg::WORD_W-1:0]           o_root
);

    localparam int NS    = v3alu_pkg::SQRT_STAGES;
    localparam int RAD_W = v3alu_pkg::PROD_W;
    localparam int RT_W  = v3alu_pkg::WORD_W;
    localparam int REM_W = RT_W + 4;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [RT_W-1:0]  root;
        logic [RAD_W-1:0] rad;
    } t_sq_st;

    t_sq_st r_st [NS];
    t_sq_st n_st [NS];

    function automatic t_sq_st sq_step(input t_sq_st s);
        t_sq_st           r;
        logic [REM_W-1:0] rem_t;
        logic [REM_W-1:0] trial;
        logic             ge;
        rem_t  = {s.rem[REM_W-3:0], s.rad[RAD_W-1:RAD_W-2]};
        trial  = {2'b00, s.root, 2'b01};
        ge     = (rem_t >= trial);
        r.rem  = ge ? (rem_t - trial) : rem_t;
        r.root = {s.root[RT_W-2:0], ge};
        r.rad  = {s.rad[RAD_W-3:0], 2'b00};
        return r;
    endfunction

    always_comb begin
        t_sq_st s0;
        s0.rem  = '0;
        s0.root = '0;
        s0.rad  = i_rad;
        n_st[0] = sq_step(s0);
        for (int k = 1; k < NS; k++) begin
            n_st[k] = sq_step(r_st[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_root = r_st[NS-1].root;

endmodule

`default_nettype wire

>>> rtl/core/v3alu_div.sv
// ============================================================================
// v3alu_div: pipelined unsigned divider
// Restoring division, one quotient bit per stage, sign carried alongside.
// ============================================================================
`default_nettype none

module v3alu_div #(
    parameter int NUM_W = v3alu_pkg::WORD_W + v3alu_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [NUM_W-1:0]                   i_num,
    input  logic [v3alu_pkg::WORD_W-1:0]       i_den,
    input  logic                               i_neg,
    output logic [NUM_W-1:0]                   o_quo,
    output logic                               o_neg
);

    localparam int DW = v3alu_pkg::WORD_W;

    typedef struct packed {
        logic [DW-1:0]    rem;
        logic [NUM_W-1:0] nq;
    } t_dv_st;

    t_dv_st        r_st  [NUM_W];
    t_dv_st        n_st  [NUM_W];
    logic [DW-1:0] r_den [NUM_W];
    logic          r_neg [NUM_W];

    function automatic t_dv_st div_step(input t_dv_st s, input logic [DW-1:0] den);
        t_dv_st      r;
        logic [DW:0] rem_t;
        logic [DW:0] diff;
        logic        ge;
        rem_t = {s.rem, s.nq[NUM_W-1]};
        diff  = rem_t - {1'b0, den};
        ge    = (rem_t >= {1'b0, den});
        r.rem = ge ? diff[DW-1:0] : rem_t[DW-1:0];
        r.nq  = {s.nq[NUM_W-2:0], ge};
        return r;
    endfunction

    always_comb begin
        t_dv_st s0;
        s0.rem  = '0;
        s0.nq   = i_num;
        n_st[0] = div_step(s0, i_den);
        for (int k = 1; k < NUM_W; k++) begin
            n_st[k] = div_step(r_st[k-1], r_den[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st     <= n_st;
            r_den[0] <= i_den;
            r_neg[0] <= i_neg;
            for (int k = 1; k < NUM_W; k++) begin
                r_den[k] <= r_den[k-1];
                r_neg[k] <= r_neg[k-1];
            end
        end
    end

    assign o_quo = r_st[NUM_W-1].nq;
    assign o_neg = r_neg[NUM_W-1];

endmodule

`default_nettype wire

>>> rtl/core/vector3_fixed_point_alu.sv
// Operands and results are Q16.16 at the default FRAC_BITS.
// Throughput: one item per cycle while the output is not stalled; the 32-stage square root and the
// (32 + FRAC_BITS)-stage dividers set the depth, not the rate.
// A stalled output holds the whole pipeline, and the input stalls with it.
// Reset clears only the valid bits; data registers are not reset.
// ============================================================================
// vector3_fixed_point_alu: 3D vector unit on signed fixed-point operands
// Three component lanes, a shared square root, three dividers and a merge.
// ============================================================================
`default_nettype none

module vector3_fixed_point_alu #(
    parameter int FRAC_BITS = v3alu_pkg::FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  v3alu_pkg::t_in_item   i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output v3alu_pkg::t_out_item  o_data
);

    localparam int WW     = v3alu_pkg::WORD_W;
    localparam int NUM_W  = WW + FRAC_BITS;
    localparam int SQ_DLY = v3alu_pkg::SQRT_STAGES;
    localparam int Q_ST   = 4 + SQ_DLY + NUM_W;
    localparam int A_W    = 4 + WW;
    localparam int B_W    = 3 * WW + 3 + WW + 1;
    localparam int C_W    = 4 + WW + 3 * WW;
    localparam int D_W    = 4 + 1 + 3 + 3 + WW;

    logic                  w_en;
    logic [Q_ST:0]         r_vld;
    v3alu_pkg::t_in_item   r_in;
    v3alu_pkg::t_vec       w_a, w_b;

    logic signed [v3alu_pkg::PROD_W-1:0] w_prod [3];
    v3alu_pkg::t_word                    w_res  [3];
    logic [2:0]                          w_ov;
    v3alu_pkg::t_word                    w_vec  [3];
    logic [v3alu_pkg::PROD_W-1:0]        w_sq   [3];

    v3alu_pkg::t_sat               n_dot, r_dot2;
    logic [v3alu_pkg::PROD_W-1:0]  r_sumsq4;
    logic [WW-1:0]                 w_root;

    logic [A_W-1:0] w_dly_a;
    logic [B_W-1:0] w_dly_b;
    logic [C_W-1:0] w_dly_c;
    logic [D_W-1:0] w_dly_d;

    v3alu_pkg::t_cmd  a_cmd;
    v3alu_pkg::t_word a_scal;

    v3alu_pkg::t_cmd  c_cmd;
    v3alu_pkg::t_word c_scal;
    v3alu_pkg::t_word c_v [3];

    logic [WW-1:0]    n_sabs;
    logic [NUM_W-1:0] n_num [3];
    logic [WW-1:0]    n_den [3];
    logic             n_neg [3];
    logic [2:0]       n_vpos, n_vneg;

    logic [NUM_W-1:0] w_quo  [3];
    logic             w_qneg [3];

    v3alu_pkg::t_cmd  d_cmd;
    logic             d_szero;
    logic [2:0]       d_vpos, d_vneg;
    logic [WW-1:0]    d_root;

    v3alu_pkg::t_word b_res [3];
    logic [2:0]       b_ov;
    v3alu_pkg::t_sat  b_dot;

    logic signed [NUM_W:0] n_qs   [3];
    v3alu_pkg::t_sat       n_qsat [3];
    v3alu_pkg::t_word      n_rv   [3];

    v3alu_pkg::t_out_item  n_out, r_out;
    logic                  r_out_valid;

    assign w_en    = !(r_out_valid && i_stall);
    assign o_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_vld       <= {r_vld[Q_ST-1:0], i_valid};
            r_out_valid <= r_vld[Q_ST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in     <= i_data;
            r_dot2   <= n_dot;
            r_sumsq4 <= w_sq[0] + w_sq[1] + w_sq[2];
            r_out    <= n_out;
        end
    end

    assign w_a = {r_in.az, r_in.ay, r_in.ax};
    assign w_b = {r_in.bz, r_in.by_comp, r_in.bx};

    for (genvar l = 0; l < 3; l++) begin : g_lane
        v3alu_lane #(
            .FRAC_BITS (FRAC_BITS),
            .LANE      (l)
        ) u_lane (
            .i_clk    (i_clk),
            .i_en     (w_en),
            .i_cmd    (r_in.cmd),
            .i_a      (w_a),
            .i_b      (w_b),
            .i_scalar (r_in.scalar),
            .o_prod   (w_prod[l]),
            .o_res    (w_res[l]),
            .o_ov     (w_ov[l]),
            .o_vec    (w_vec[l]),
            .o_sq     (w_sq[l])
        );
    end

    assign n_dot = v3alu_pkg::trunc_sat(
        v3alu_pkg::ACC_W'(w_prod[0]) + v3alu_pkg::ACC_W'(w_prod[1])
        + v3alu_pkg::ACC_W'(w_prod[2]), FRAC_BITS);

    v3alu_delay #(.WIDTH(A_W), .DEPTH(3)) u_dly_a (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   ({r_in.cmd, r_in.scalar}),
        .o_d   (w_dly_a)
    );
    assign {a_cmd, a_scal} = w_dly_a;

    v3alu_delay #(.WIDTH(B_W), .DEPTH(Q_ST - 2)) u_dly_b (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   ({w_res[2], w_res[1], w_res[0], w_ov, r_dot2}),
        .o_d   (w_dly_b)
    );
    assign {b_res[2], b_res[1], b_res[0], b_ov, b_dot} = w_dly_b;

    v3alu_delay #(.WIDTH(C_W), .DEPTH(SQ_DLY + 1)) u_dly_c (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   ({a_cmd, a_scal, w_vec[2], w_vec[1], w_vec[0]}),
        .o_d   (w_dly_c)
    );
    assign {c_cmd, c_scal, c_v[2], c_v[1], c_v[0]} = w_dly_c;

    v3alu_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r_sumsq4),
        .o_root (w_root)
    );

    always_comb begin
        n_sabs = c_scal[WW-1] ? WW'(-c_scal) : WW'(c_scal);
        for (int l = 0; l < 3; l++) begin
            n_num[l]  = {(c_v[l][WW-1] ? WW'(-c_v[l]) : WW'(c_v[l])), {FRAC_BITS{1'b0}}};
            n_vpos[l] = !c_v[l][WW-1] && (c_v[l] != '0);
            n_vneg[l] = c_v[l][WW-1];
            if (c_cmd == v3alu_pkg::CMD_DIV) begin
                n_den[l] = n_sabs;
                n_neg[l] = c_v[l][WW-1] ^ c_scal[WW-1];
            end else begin
                n_den[l] = w_root;
                n_neg[l] = c_v[l][WW-1];
            end
        end
    end

    for (genvar l = 0; l < 3; l++) begin : g_div
        v3alu_div #(.NUM_W(NUM_W)) u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (n_num[l]),
            .i_den (n_den[l]),
            .i_neg (n_neg[l]),
            .o_quo (w_quo[l]),
            .o_neg (w_qneg[l])
        );
    end

    v3alu_delay #(.WIDTH(D_W), .DEPTH(NUM_W)) u_dly_d (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   ({c_cmd, (c_scal == '0), n_vpos, n_vneg, w_root}),
        .o_d   (w_dly_d)
    );
    assign {d_cmd, d_szero, d_vpos, d_vneg, d_root} = w_dly_d;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_qs[l]   = w_qneg[l] ? -$signed({1'b0, w_quo[l]}) : $signed({1'b0, w_quo[l]});
            n_qsat[l] = v3alu_pkg::sat32(v3alu_pkg::ACC_W'(n_qs[l]));
            n_rv[l]   = '0;
        end
        n_out = '0;
        case (d_cmd) inside
            v3alu_pkg::CMD_ADD, v3alu_pkg::CMD_SUB, v3alu_pkg::CMD_CROSS,
            v3alu_pkg::CMD_SCALE: begin
                for (int l = 0; l < 3; l++) begin
                    n_rv[l] = b_res[l];
                end
                n_out.overflow = |b_ov;
            end
            v3alu_pkg::CMD_DOT: begin
                n_out.res_scalar = b_dot.val;
                n_out.overflow   = b_dot.ov;
            end
            v3alu_pkg::CMD_DIV: begin
                if (d_szero) begin
                    n_out.div_zero = 1'b1;
                    for (int l = 0; l < 3; l++) begin
                        n_rv[l] = d_vpos[l] ? v3alu_pkg::WORD_MAX :
                                  (d_vneg[l] ? v3alu_pkg::WORD_MIN : '0);
                    end
                end else begin
                    for (int l = 0; l < 3; l++) begin
                        n_rv[l] = n_qsat[l].val;
                    end
                    n_out.overflow = n_qsat[0].ov | n_qsat[1].ov | n_qsat[2].ov;
                end
            end
            v3alu_pkg::CMD_MAG: begin
                if (d_root[WW-1]) begin
                    n_out.res_scalar = v3alu_pkg::WORD_MAX;
                    n_out.overflow   = 1'b1;
                end else begin
                    n_out.res_scalar = d_root;
                end
            end
            v3alu_pkg::CMD_UNIT, v3alu_pkg::CMD_ORTH: begin
                if (d_root != '0) begin
                    for (int l = 0; l < 3; l++) begin
                        n_rv[l] = n_qsat[l].val;
                    end
                end
                if (d_cmd == v3alu_pkg::CMD_ORTH) begin
                    n_out.overflow = |b_ov;
                end
            end
            default: begin
            end
        endcase
        n_out.res_x = n_rv[0];
        n_out.res_y = n_rv[1];
        n_out.res_z = n_rv[2];
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire
